### hdl/hash_set_insert_remove_lookup_unit_assert.svh
// assertion macros used by hash_set_insert_remove_lookup_unit
`ifndef HASH_SET_INSERT_REMOVE_LOOKUP_UNIT_ASSERT_SVH
`define HASH_SET_INSERT_REMOVE_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication
`define HSIRL_ASSERT_IMP(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("hsirl assertion failed");

// next-cycle implication
`define HSIRL_ASSERT_NXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("hsirl assertion failed");

`endif

### hdl/hsirl_pkg.sv
`timescale 1ns / 1ps
package hsirl_pkg;

	localparam int BUCKETS = 7;
	localparam int WAYS    = 4;
	localparam int SLOTS   = BUCKETS * WAYS;

	localparam int KEY_W    = 31;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int IDX_W    = 3;

	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// key / BUCKETS as (key * RECIP) >> RECIP_SH, exact over the whole key range
	localparam int              RECIP_SH = KEY_W + $clog2(BUCKETS);
	localparam int              RECIP_W  = KEY_W + 1;
	localparam longint unsigned RECIP    = ((64'd1 << RECIP_SH) + BUCKETS - 1) / BUCKETS;
	localparam int              PROD_W   = KEY_W + RECIP_W;

	localparam int S_DATA_W = ((CMD_W + KEY_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((STATUS_W + IDX_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_ALREADY   = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_PRESENT   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_RD,
		S_CMP,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic             done;
		logic [BKT_W-1:0] rem;
	} mod_res_t;

endpackage

### hdl/hash_set_insert_remove_lookup_unit.sv
`timescale 1ns / 1ps
// hash set of 31-bit keys, BUCKETS buckets of WAYS slots, bucket = key mod BUCKETS
// input stream s_*: one command per transfer (insert, remove or query a key)
// output stream m_*: one status transfer per command, with the bucket number
// each command runs alone through a small sequencer:
//   - the hash unit forms key mod BUCKETS as a registered reciprocal multiply,
//     then a registered multiply-back and subtract
//   - the bucket row is then scanned one way at a time through the key ram,
//     each way in a read step, then a compare against the registered ram data
//   - a last step applies the update and loads the output register
// s_tready is high only while the sequencer is idle, so a new command is not taken
// until the previous one has gone through its last step
// a finished status sits in the output register while the next command is taken;
// if the receiver still holds the previous one, the sequencer waits in its last step
// reset clears the slot valid flags, the sequencer and m_tvalid; the key ram needs no
// clearing since a key is only looked at when its valid flag is set
module hash_set_insert_remove_lookup_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hsirl_pkg::S_DATA_W-1:0] s_tdata,  // command[1:0], key[32:2]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hsirl_pkg::M_DATA_W-1:0] m_tdata   // status[2:0], bucket_index[5:3]
);
	import hsirl_pkg::*;

	state_t           state_q;
	state_t           next_state;
	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [BKT_W-1:0] bucket_q;
	logic [SLOT_W-1:0] base_q;
	logic [WAY_W-1:0] way_q;
	logic             hit_q;
	logic             free_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [SLOT_W-1:0] free_slot_q;
	logic             valid_q [SLOTS];
	logic             m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic             accept;
	logic             out_free;
	logic             last_way;
	logic [SLOT_W-1:0] slot_addr;
	logic [KEY_W-1:0] ram_rdata;
	logic             key_match;
	logic             do_set;
	logic             do_clear;
	logic             exec_go;
	status_t          status;
	mod_res_t         mod_res;

	assign accept    = s_tvalid & s_tready;
	assign out_free  = ~m_tvalid_q | m_tready;
	assign last_way  = (way_q == WAY_W'(WAYS - 1));
	assign slot_addr = base_q + SLOT_W'(way_q);
	assign key_match = (ram_rdata == key_q);
	assign exec_go   = (state_q == S_EXEC) && out_free;

	hsirl_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_tdata[CMD_W +: KEY_W]),
		.res    (mod_res)
	);

	hsirl_ram #(
		.WIDTH (KEY_W),
		.DEPTH (SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (do_set),
		.waddr (free_slot_q),
		.wdata (key_q),
		.raddr (slot_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		next_state = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) next_state = S_HASH;
			end
			S_HASH: begin
				if (mod_res.done) next_state = S_RD;
			end
			S_RD: begin
				next_state = S_CMP;
			end
			S_CMP: begin
				next_state = last_way ? S_EXEC : S_RD;
			end
			S_EXEC: begin
				if (out_free) next_state = S_IDLE;
			end
			default: next_state = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		do_set   = 1'b0;
		do_clear = 1'b0;
		status   = ST_NOT_FOUND;
		unique case (cmd_t'(cmd_q))
			CMD_INSERT: begin
				if (hit_q) begin
					status = ST_ALREADY;
				end else if (!free_q) begin
					status = ST_FULL;
				end else begin
					status = ST_INSERTED;
					do_set = exec_go;
				end
			end
			CMD_REMOVE: begin
				if (hit_q) begin
					status   = ST_REMOVED;
					do_clear = exec_go;
				end
			end
			default: begin
				// query, and the unused code behaves the same
				status = hit_q ? ST_PRESENT : ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			state_q <= next_state;
			if (exec_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (do_set) begin
				valid_q[free_slot_q] <= 1'b1;
			end
			if (do_clear) begin
				valid_q[hit_slot_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tdata[CMD_W-1:0];
			key_q  <= s_tdata[CMD_W +: KEY_W];
			way_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end
		if (state_q == S_HASH && mod_res.done) begin
			bucket_q <= mod_res.rem;
			base_q   <= SLOT_W'(mod_res.rem * WAYS);
		end
		if (state_q == S_CMP) begin
			// first matching valid slot, first empty slot
			if (valid_q[slot_addr]) begin
				if (!hit_q && key_match) begin
					hit_q      <= 1'b1;
					hit_slot_q <= slot_addr;
				end
			end else if (!free_q) begin
				free_q      <= 1'b1;
				free_slot_q <= slot_addr;
			end
			if (!last_way) begin
				way_q <= way_q + 1'b1;
			end
		end
		if (exec_go) begin
			m_tdata_q <= M_DATA_W'({IDX_W'(bucket_q), status});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "hash_set_insert_remove_lookup_unit_assert.svh"

	`HSIRL_ASSERT_NXT(a_accept_starts_hash, clk, arst_n, accept, state_q == S_HASH)
	`HSIRL_ASSERT_IMP(a_result_from_exec, clk, arst_n, $rose(m_tvalid), $past(state_q) == S_EXEC)
	`HSIRL_ASSERT_NXT(a_insert_sets_valid, clk, arst_n, do_set, valid_q[$past(free_slot_q)])
	`HSIRL_ASSERT_IMP(a_no_set_and_clear, clk, arst_n, do_set, !do_clear)

endmodule

### hdl/hsirl_ram.sv
`timescale 1ns / 1ps
module hsirl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/hsirl_mod_unit.sv
`timescale 1ns / 1ps
module hsirl_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hsirl_pkg::KEY_W-1:0] key,
	output hsirl_pkg::mod_res_t         res
);
	import hsirl_pkg::*;

	logic              vld_s1;
	logic              done_s2;
	logic [KEY_W-1:0]  key_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [BKT_W-1:0]  rem_s2;
	logic [KEY_W-1:0]  quot;
	logic [KEY_W-1:0]  rem_full;

	// quotient from the reciprocal product, then multiply back and subtract
	assign quot     = KEY_W'(prod_s1 >> RECIP_SH);
	assign rem_full = key_s1 - KEY_W'(quot * KEY_W'(BUCKETS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= start;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_s1  <= key;
			prod_s1 <= PROD_W'(key) * PROD_W'(RECIP);
		end
		if (vld_s1) begin
			rem_s2 <= BKT_W'(rem_full);
		end
	end

	assign res.done = done_s2;
	assign res.rem  = rem_s2;

endmodule
